/* sv/scmd_pkg.sv */
// Shared types and constants for the serial command tokenizer.
`timescale 1ns / 1ps

package scmd_pkg;

    localparam int MAX_PARAMS = 10;
    localparam int NAME_CHARS = 8;
    localparam int NUM_NAMES  = 6;

    localparam int BYTE_W     = 8;
    localparam int NAME_W     = 64;
    localparam int COUNT_W    = 3;
    localparam int REG_IDX_W  = 3;
    localparam int LEN_W      = 4;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 3;

    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NAME     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NAME_END = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PARAM    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SEP      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_END      = 3'd6;

    localparam logic [REG_IDX_W-1:0] REG_NAME_COUNT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NAME_WORD_0 = 3'd1;

    typedef struct packed {
        logic [COUNT_W-1:0]                 name_count;
        logic [NUM_NAMES-1:0][NAME_W-1:0]   name_word;
    } scmd_cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    tok_byte;
        logic [SLOT_W-1:0]    slot;
        logic                 query;
        logic [NUM_NAMES-1:0] mask;
        logic [SLOT_W-1:0]    total;
        logic                 seen;
        logic                 name_ovf;
        logic                 param_ovf;
    } scmd_result_t;

endpackage

/* sv/scmd_cfg_regs.sv */
// Configuration register file: name count and registered command names.
`timescale 1ns / 1ps

module scmd_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [scmd_pkg::REG_IDX_W-1:0]    cfg_wr_index,
    input  logic [scmd_pkg::NAME_W-1:0]       cfg_wr_data,
    output scmd_pkg::scmd_cfg_t               cfg
);

    scmd_pkg::scmd_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == scmd_pkg::REG_NAME_COUNT) begin
                cfg_reg.name_count <= cfg_wr_data[scmd_pkg::COUNT_W-1:0];
            end
            for (int k = 0; k < scmd_pkg::NUM_NAMES; k++) begin
                if (cfg_wr_index ==
                    scmd_pkg::REG_NAME_WORD_0 + scmd_pkg::REG_IDX_W'(k)) begin
                    cfg_reg.name_word[k] <= cfg_wr_data;
                end
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/scmd_core.sv */
// Parse phase machine, name packing, parameter counting and name matching.
`timescale 1ns / 1ps

module scmd_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [scmd_pkg::BYTE_W-1:0]   rx_byte,
    input  scmd_pkg::scmd_cfg_t           cfg,
    output scmd_pkg::scmd_result_t        result
);

    localparam logic [1:0] PH_WAIT  = 2'd0;
    localparam logic [1:0] PH_NAME  = 2'd1;
    localparam logic [1:0] PH_PARAM = 2'd2;

    logic [1:0]                   phase_reg, phase_next;
    logic                         query_reg, query_next;
    logic [scmd_pkg::NAME_W-1:0]  name_reg, name_next;
    logic [scmd_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [scmd_pkg::SLOT_W-1:0]  cnt_reg, cnt_next;
    logic                         novf_reg, novf_next;
    logic                         povf_reg, povf_next;
    logic [scmd_pkg::NUM_NAMES-1:0] match;

    always_comb begin
        match = '0;
        for (int k = 0; k < scmd_pkg::NUM_NAMES; k++) begin
            match[k] = (scmd_pkg::COUNT_W'(k) < cfg.name_count) &&
                       (cfg.name_word[k] == name_reg);
        end
        if (novf_reg) begin
            match = '0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        query_next = query_reg;
        name_next  = name_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        novf_next  = novf_reg;
        povf_next  = povf_reg;
        result     = '0;
        result.tok_byte = rx_byte;

        if (rx_byte == scmd_pkg::CH_SEMI) begin
            result.kind = scmd_pkg::KIND_END;
            if (phase_reg != PH_WAIT) begin
                result.seen  = 1'b1;
                result.query = query_reg;
                result.mask  = match;
                if (!query_reg && phase_reg == PH_PARAM) begin
                    result.total = cnt_reg + 1'b1;
                end
            end
            result.name_ovf  = novf_reg;
            result.param_ovf = povf_reg;
            phase_next = PH_WAIT;
            query_next = 1'b0;
            name_next  = '0;
            len_next   = '0;
            cnt_next   = '0;
            novf_next  = 1'b0;
            povf_next  = 1'b0;
        end else begin
            case (phase_reg)
                PH_WAIT: begin
                    if (rx_byte == scmd_pkg::CH_BANG || rx_byte == scmd_pkg::CH_QUERY) begin
                        result.kind = scmd_pkg::KIND_START;
                        phase_next  = PH_NAME;
                        query_next  = (rx_byte == scmd_pkg::CH_QUERY);
                    end
                end
                PH_NAME: begin
                    if (rx_byte == scmd_pkg::CH_SPACE) begin
                        result.kind = scmd_pkg::KIND_NAME_END;
                        phase_next  = PH_PARAM;
                    end else begin
                        result.kind = scmd_pkg::KIND_NAME;
                        if (len_reg < scmd_pkg::LEN_W'(scmd_pkg::NAME_CHARS)) begin
                            name_next[8*len_reg[2:0] +: 8] = rx_byte;
                            len_next = len_reg + 1'b1;
                        end else begin
                            novf_next = 1'b1;
                        end
                    end
                end
                PH_PARAM: begin
                    if (!query_reg && !povf_reg) begin
                        if (rx_byte == scmd_pkg::CH_COMMA) begin
                            if ({1'b0, cnt_reg} + 5'd1 >= 5'(scmd_pkg::MAX_PARAMS)) begin
                                povf_next = 1'b1;
                            end else begin
                                result.kind = scmd_pkg::KIND_SEP;
                                result.slot = cnt_reg;
                                cnt_next    = cnt_reg + 1'b1;
                            end
                        end else begin
                            result.kind = scmd_pkg::KIND_PARAM;
                            result.slot = cnt_reg;
                        end
                    end
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase
            if (phase_next != PH_WAIT) begin
                result.query = query_next;
            end
            result.name_ovf  = novf_next;
            result.param_ovf = povf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAIT;
            query_reg <= 1'b0;
            name_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            novf_reg  <= 1'b0;
            povf_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            query_reg <= query_next;
            name_reg  <= name_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            novf_reg  <= novf_next;
            povf_reg  <= povf_next;
        end
    end

endmodule

/* sv/scmd_out_reg.sv */
// Result register with valid flag on the output channel.
`timescale 1ns / 1ps

module scmd_out_reg (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  scmd_pkg::scmd_result_t  result,
    input  logic                    m_ready,
    output logic                    m_valid,
    output logic                    free,
    output scmd_pkg::scmd_result_t  held
);

    logic                   valid_reg;
    scmd_pkg::scmd_result_t data_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign held    = data_reg;

endmodule

/* sv/serial_command_tokenizer_unit.sv */
// Top level of the serial command tokenizer: input register, parser, result register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_rx_byte
// m_        out        m_valid/m_ready    m_token_kind .. m_param_overflow
// cfg_      in         cfg_wr_en          cfg_wr_index, cfg_wr_data
//
// One byte per cycle sustained while m_ready holds; each byte is registered in the input
// register and then in the result register before its result is offered on the m_ channel.
// The parser state advances when the input register moves into the result register.
// A stalled result register holds the input register; one further byte is buffered.
// Synchronous active-low reset clears command state, valid flags and config registers.

module serial_command_tokenizer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [scmd_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [scmd_pkg::KIND_W-1:0]        m_token_kind,
    output logic [scmd_pkg::BYTE_W-1:0]        m_token_byte,
    output logic [scmd_pkg::SLOT_W-1:0]        m_param_slot,
    output logic                               m_query_flag,
    output logic [scmd_pkg::NUM_NAMES-1:0]     m_match_mask,
    output logic [scmd_pkg::SLOT_W-1:0]        m_arg_total,
    output logic                               m_start_seen,
    output logic                               m_name_overflow,
    output logic                               m_param_overflow,
    input  logic                               cfg_wr_en,
    input  logic [scmd_pkg::REG_IDX_W-1:0]     cfg_wr_index,
    input  logic [scmd_pkg::NAME_W-1:0]        cfg_wr_data
);

    logic                          in_valid_reg;
    logic [scmd_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          out_free;
    logic                          step;
    scmd_pkg::scmd_cfg_t           cfg;
    scmd_pkg::scmd_result_t        result;
    scmd_pkg::scmd_result_t        held;

    assign step    = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    scmd_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    scmd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    scmd_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .result  (result),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .free    (out_free),
        .held    (held)
    );

    assign m_token_kind     = held.kind;
    assign m_token_byte     = held.tok_byte;
    assign m_param_slot     = held.slot;
    assign m_query_flag     = held.query;
    assign m_match_mask     = held.mask;
    assign m_arg_total      = held.total;
    assign m_start_seen     = held.seen;
    assign m_name_overflow  = held.name_ovf;
    assign m_param_overflow = held.param_ovf;

endmodule

/* sim/serial_command_tokenizer_unit_tb.sv */
// Self-checking testbench for the serial command tokenizer: directed and random byte streams.
`timescale 1ns / 1ps

module serial_command_tokenizer_unit_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 40;

    typedef enum logic [1:0] {AWAIT_MARK, IN_NAME, IN_PARAMS} cmd_phase_t;

    logic                                 aclk = 1'b0;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [scmd_pkg::BYTE_W-1:0]          s_rx_byte;
    logic                                 m_valid;
    logic                                 m_ready;
    logic [scmd_pkg::KIND_W-1:0]          m_token_kind;
    logic [scmd_pkg::BYTE_W-1:0]          m_token_byte;
    logic [scmd_pkg::SLOT_W-1:0]          m_param_slot;
    logic                                 m_query_flag;
    logic [scmd_pkg::NUM_NAMES-1:0]       m_match_mask;
    logic [scmd_pkg::SLOT_W-1:0]          m_arg_total;
    logic                                 m_start_seen;
    logic                                 m_name_overflow;
    logic                                 m_param_overflow;
    logic                                 cfg_wr_en;
    logic [scmd_pkg::REG_IDX_W-1:0]       cfg_wr_index;
    logic [scmd_pkg::NAME_W-1:0]          cfg_wr_data;

    // copy of the name table as written into the block
    logic [scmd_pkg::COUNT_W-1:0]         cfg_count = '0;
    logic [scmd_pkg::NAME_W-1:0]          cfg_word [scmd_pkg::NUM_NAMES];
    int                                   name_len [scmd_pkg::NUM_NAMES];
    logic [scmd_pkg::NAME_W-1:0]          stage_word [scmd_pkg::NUM_NAMES];
    int                                   stage_len [scmd_pkg::NUM_NAMES];

    // command state of the predictor
    cmd_phase_t                           cmd_phase = AWAIT_MARK;
    logic                                 cmd_query = 1'b0;
    logic [scmd_pkg::NAME_W-1:0]          cmd_name = '0;
    int                                   cmd_name_len = 0;
    int                                   cmd_param = 0;
    logic                                 cmd_name_ovf = 1'b0;
    logic                                 cmd_param_ovf = 1'b0;

    scmd_pkg::scmd_result_t               pending_tokens [$];
    scmd_pkg::scmd_result_t               want;
    int                                   mismatch_count = 0;
    int                                   tokens_seen = 0;
    int                                   items_sent = 0;
    int                                   cycle_count = 0;
    bit                                   tx_steady = 1'b0;
    bit                                   rx_steady = 1'b0;
    int                                   rx_hold_cycles = 0;
    int                                   rx_stall = 0;

    serial_command_tokenizer_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_token_kind     (m_token_kind),
        .m_token_byte     (m_token_byte),
        .m_param_slot     (m_param_slot),
        .m_query_flag     (m_query_flag),
        .m_match_mask     (m_match_mask),
        .m_arg_total      (m_arg_total),
        .m_start_seen     (m_start_seen),
        .m_name_overflow  (m_name_overflow),
        .m_param_overflow (m_param_overflow),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [scmd_pkg::BYTE_W-1:0] pick_name_byte();
        logic [scmd_pkg::BYTE_W-1:0] b;
        do b = scmd_pkg::BYTE_W'($urandom_range(0, 255));
        while (b == scmd_pkg::CH_SPACE || b == scmd_pkg::CH_SEMI);
        return b;
    endfunction

    function automatic logic [scmd_pkg::BYTE_W-1:0] pick_param_byte();
        logic [scmd_pkg::BYTE_W-1:0] b;
        do b = scmd_pkg::BYTE_W'($urandom_range(0, 255));
        while (b == scmd_pkg::CH_COMMA || b == scmd_pkg::CH_SEMI);
        return b;
    endfunction

    function automatic logic [scmd_pkg::NUM_NAMES-1:0] matching_names();
        int                             lim;
        logic [scmd_pkg::NUM_NAMES-1:0] m;
        m = '0;
        lim = (int'(cfg_count) > scmd_pkg::NUM_NAMES) ? scmd_pkg::NUM_NAMES
                                                       : int'(cfg_count);
        if (!cmd_name_ovf) begin
            for (int k = 0; k < lim; k++) begin
                if (cfg_word[k] == cmd_name) m[k] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic scmd_pkg::scmd_result_t tokenize_byte(
        input logic [scmd_pkg::BYTE_W-1:0] c);
        scmd_pkg::scmd_result_t tok;
        tok = '0;
        tok.kind = scmd_pkg::KIND_IGNORED;
        tok.tok_byte = c;
        if (c == scmd_pkg::CH_SEMI) begin
            tok.kind = scmd_pkg::KIND_END;
            if (cmd_phase != AWAIT_MARK) begin
                tok.seen = 1'b1;
                tok.query = cmd_query;
                tok.mask = matching_names();
                if (!cmd_query && cmd_phase == IN_PARAMS)
                    tok.total = scmd_pkg::SLOT_W'(cmd_param + 1);
            end
            tok.name_ovf = cmd_name_ovf;
            tok.param_ovf = cmd_param_ovf;
            cmd_phase = AWAIT_MARK;
            cmd_query = 1'b0;
            cmd_name = '0;
            cmd_name_len = 0;
            cmd_param = 0;
            cmd_name_ovf = 1'b0;
            cmd_param_ovf = 1'b0;
        end else begin
            case (cmd_phase)
                AWAIT_MARK: begin
                    if (c == scmd_pkg::CH_BANG || c == scmd_pkg::CH_QUERY) begin
                        tok.kind = scmd_pkg::KIND_START;
                        cmd_phase = IN_NAME;
                        cmd_query = (c == scmd_pkg::CH_QUERY);
                    end
                end
                IN_NAME: begin
                    if (c == scmd_pkg::CH_SPACE) begin
                        tok.kind = scmd_pkg::KIND_NAME_END;
                        cmd_phase = IN_PARAMS;
                    end else begin
                        tok.kind = scmd_pkg::KIND_NAME;
                        if (cmd_name_len < scmd_pkg::NAME_CHARS) begin
                            cmd_name[8*cmd_name_len +: 8] = c;
                            cmd_name_len++;
                        end else begin
                            cmd_name_ovf = 1'b1;
                        end
                    end
                end
                default: begin
                    if (!cmd_query && !cmd_param_ovf) begin
                        if (c == scmd_pkg::CH_COMMA) begin
                            if (cmd_param + 1 >= scmd_pkg::MAX_PARAMS) begin
                                cmd_param_ovf = 1'b1;
                            end else begin
                                tok.kind = scmd_pkg::KIND_SEP;
                                tok.slot = scmd_pkg::SLOT_W'(cmd_param);
                                cmd_param++;
                            end
                        end else begin
                            tok.kind = scmd_pkg::KIND_PARAM;
                            tok.slot = scmd_pkg::SLOT_W'(cmd_param);
                        end
                    end
                end
            endcase
            if (cmd_phase != AWAIT_MARK) tok.query = cmd_query;
            tok.name_ovf = cmd_name_ovf;
            tok.param_ovf = cmd_param_ovf;
        end
        return tok;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("t=%0t token %0d: %s expected 0x%0h got 0x%0h",
                     $time, tokens_seen, what, exp_v, got_v);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch("token with nothing pending, byte", '0, m_token_byte);
            end else begin
                want = pending_tokens.pop_front();
                if (m_token_kind != want.kind)
                    report_mismatch("token_kind", want.kind, m_token_kind);
                if (m_token_byte != want.tok_byte)
                    report_mismatch("token_byte", want.tok_byte, m_token_byte);
                if (m_param_slot != want.slot)
                    report_mismatch("param_slot", want.slot, m_param_slot);
                if (m_query_flag != want.query)
                    report_mismatch("query_flag", want.query, m_query_flag);
                if (m_match_mask != want.mask)
                    report_mismatch("match_mask", want.mask, m_match_mask);
                if (m_arg_total != want.total)
                    report_mismatch("arg_total", want.total, m_arg_total);
                if (m_start_seen != want.seen)
                    report_mismatch("start_seen", want.seen, m_start_seen);
                if (m_name_overflow != want.name_ovf)
                    report_mismatch("name_overflow", want.name_ovf, m_name_overflow);
                if (m_param_overflow != want.param_ovf)
                    report_mismatch("param_overflow", want.param_ovf, m_param_overflow);
            end
            tokens_seen++;
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                if (rx_stall == 0 && !rx_steady && $urandom_range(0, 3) == 0)
                    rx_stall = pick_gap();
                if (rx_stall > 0) begin
                    m_ready <= 1'b0;
                    rx_stall--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_byte(input logic [scmd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        pending_tokens.push_back(tokenize_byte(b));
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [scmd_pkg::REG_IDX_W-1:0] idx,
                             input logic [scmd_pkg::NAME_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        if (idx == scmd_pkg::REG_NAME_COUNT) cfg_count = data[scmd_pkg::COUNT_W-1:0];
        else cfg_word[idx - scmd_pkg::REG_NAME_WORD_0] = data;
    endtask

    task automatic program_names(input logic [scmd_pkg::COUNT_W-1:0] count);
        drain_results();
        write_reg(scmd_pkg::REG_NAME_COUNT, scmd_pkg::NAME_W'(count));
        for (int k = 0; k < scmd_pkg::NUM_NAMES; k++) begin
            write_reg(scmd_pkg::REG_IDX_W'(int'(scmd_pkg::REG_NAME_WORD_0) + k),
                      stage_word[k]);
            name_len[k] = stage_len[k];
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic draw_names();
        int r;
        for (int k = 0; k < scmd_pkg::NUM_NAMES; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                stage_word[k] = '0;
                stage_len[k] = 0;
            end else if (r == 1) begin
                stage_word[k] = '1;
                stage_len[k] = scmd_pkg::NAME_CHARS;
            end else if (r == 2 && k > 0) begin
                stage_word[k] = stage_word[k-1];
                stage_len[k] = stage_len[k-1];
            end else begin
                stage_word[k] = '0;
                stage_len[k] = $urandom_range(1, scmd_pkg::NAME_CHARS);
                for (int i = 0; i < stage_len[k]; i++)
                    stage_word[k][8*i +: 8] = pick_name_byte();
            end
        end
    endtask

    task automatic send_name_word(input int k);
        for (int i = 0; i < name_len[k]; i++) send_byte(cfg_word[k][8*i +: 8]);
    endtask

    task automatic send_random_command();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, 3))
                send_byte(scmd_pkg::BYTE_W'($urandom_range(0, 255)));
            return;
        end
        send_byte(($urandom_range(0, 3) == 0) ? scmd_pkg::CH_QUERY : scmd_pkg::CH_BANG);
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send_name_word($urandom_range(0, scmd_pkg::NUM_NAMES - 1));
        end else begin
            n = (r < 65) ? $urandom_range(scmd_pkg::NAME_CHARS + 1, scmd_pkg::NAME_CHARS + 4)
                         : $urandom_range(0, 6);
            repeat (n) send_byte(pick_name_byte());
        end
        if ($urandom_range(0, 9) < 7) begin
            send_byte(scmd_pkg::CH_SPACE);
            n = ($urandom_range(0, 9) == 0)
                ? $urandom_range(scmd_pkg::MAX_PARAMS, scmd_pkg::MAX_PARAMS + 3)
                : $urandom_range(1, 4);
            for (int p = 0; p < n; p++) begin
                if (p > 0) send_byte(scmd_pkg::CH_COMMA);
                repeat ($urandom_range(0, 3)) send_byte(pick_param_byte());
            end
        end
        // an unterminated command now and then
        if ($urandom_range(0, 19) != 0) send_byte(scmd_pkg::CH_SEMI);
    endtask

    task automatic run_traffic(input int n);
        int first;
        first = items_sent;
        while (items_sent - first < n) send_random_command();
    endtask

    task automatic test_stray_bytes();
        send_text("x");
        send_byte(scmd_pkg::CH_SEMI);
        send_byte(scmd_pkg::CH_BANG);
        send_byte(scmd_pkg::CH_SEMI);
    endtask

    task automatic test_query_command();
        send_byte(scmd_pkg::CH_QUERY);
        send_text("ab");
        send_byte(scmd_pkg::CH_SPACE);
        send_text("q");
        send_byte(scmd_pkg::CH_BANG);
        send_byte(scmd_pkg::CH_SEMI);
    endtask

    task automatic test_empty_name();
        send_byte(scmd_pkg::CH_BANG);
        send_byte(scmd_pkg::CH_SEMI);
    endtask

    task automatic test_param_list();
        send_byte(scmd_pkg::CH_BANG);
        send_text("ab");
        send_byte(scmd_pkg::CH_SPACE);
        send_text("1");
        send_byte(scmd_pkg::CH_QUERY);
        send_byte(scmd_pkg::CH_COMMA);
        send_byte(scmd_pkg::CH_SEMI);
    endtask

    task automatic test_overflow_limits();
        send_byte(scmd_pkg::CH_BANG);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_text("abcdefg");
        send_byte(scmd_pkg::CH_SPACE);
        repeat (scmd_pkg::MAX_PARAMS) send_byte(scmd_pkg::CH_COMMA);
        send_text("z");
        send_byte(scmd_pkg::CH_SEMI);
    endtask

    task automatic test_name_sweeps();
        logic [scmd_pkg::COUNT_W-1:0] count;
        for (int p = 0; p < 8; p++) begin
            draw_names();
            if (p == 0) count = '0;
            else if (p == 1) count = '1;
            else if (p == 2) count = scmd_pkg::COUNT_W'(scmd_pkg::NUM_NAMES);
            else count = scmd_pkg::COUNT_W'($urandom_range(0, 7));
            program_names(count);
            run_traffic(190);
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        rx_hold_cycles = 60;
        tx_steady = 1'b1;
        run_traffic(40);
        tx_steady = 1'b0;
        drain_results();
        run_traffic(40);
    endtask

    task automatic test_steady_stream();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_traffic(120);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data = '0;
        for (int k = 0; k < scmd_pkg::NUM_NAMES; k++) begin
            cfg_word[k] = '0;
            name_len[k] = 0;
            stage_word[k] = '0;
            stage_len[k] = 0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_stray_bytes();
        stage_word[0] = 64'h6261;  // "ab"
        stage_len[0] = 2;
        program_names('1);
        test_query_command();
        test_empty_name();
        test_param_list();
        test_overflow_limits();
        test_name_sweeps();
        test_backpressure();
        test_steady_stream();

        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
